>>> sv/pqts_pkg.sv
// pqts_pkg: shared widths, constants and types of the projected quad texture sizer.
// No dependencies; imported by pqts_unit, pqts_tail, projected_quad_texture_size and the testbench.
package pqts_pkg;

   localparam int MAG_W        = 31;  // block-scaled corner magnitude, MSB at bit 30
   localparam int SUMSQ_W      = 64;  // sum of three squares
   localparam int NORM_W       = 32;  // vector length
   localparam int QUO_W        = 30;  // unit component magnitude, Q1.29
   localparam int UNIT_W       = 31;  // signed unit component
   localparam int DIFF_W       = 32;  // signed diagonal component
   localparam int PROD_W       = 64;  // signed diagonal product
   localparam int CMAG_W       = 32;  // cross magnitude after the Q.28 shift
   localparam int CROSS_SHIFT  = 30;
   localparam int LEN_W        = 32;
   localparam int LEN_SHIFT    = 29;
   localparam int ROOT_W       = 31;
   localparam int PPD_W        = 16;
   localparam int RADIUS_W     = 30;
   localparam int RADIUS_SHIFT = 16;
   localparam int RQ_W         = RADIUS_W + ROOT_W;
   localparam int ROUND_SHIFT  = 45;
   localparam int RAW_W        = RQ_W + 1 - ROUND_SHIFT;

   localparam logic [RADIUS_W-1:0] RAD_TO_DEG_Q24 = 30'd961263669;
   localparam logic [PPD_W-1:0]    PPD_RESET      = 16'd2560;

   typedef struct packed {
      logic signed [UNIT_W-1:0] x;
      logic signed [UNIT_W-1:0] y;
      logic signed [UNIT_W-1:0] z;
   } uvec_type;

   typedef struct packed {
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][MAG_W-1:0]  mag;
   } corner_side_type;

   typedef struct packed {
      logic zero;
      logic neg;
   } lane_side_type;

endpackage

>>> sv/pqts_isqrt.sv
// pqts_isqrt: pipelined floor square root, one root bit per register stage.
// Carries a sideband word alongside; standalone, no package dependency.
module pqts_isqrt #(
   parameter int RW = 32,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_vld,
   input  logic [2*RW-1:0] in_val,
   input  logic [SW-1:0]   in_side,
   output logic            out_vld,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] val_ff  [RW];
   logic [SW-1:0]   side_ff [RW];
   logic            vld_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RW+1:0]   prev_rem;
      logic [RW-1:0]   prev_root;
      logic [2*RW-1:0] prev_val;
      logic [SW-1:0]   prev_side;
      logic            prev_vld;
      logic [RW+1:0]   rem_sh;
      logic [RW+1:0]   trial;
      logic [RW+1:0]   rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_val  = in_val;
         assign prev_side = in_side;
         assign prev_vld  = in_vld;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_val  = val_ff[k-1];
         assign prev_side = side_ff[k-1];
         assign prev_vld  = vld_ff[k-1];
      end

      // bring down the next two bits and try the next root bit
      assign rem_sh = {prev_rem[RW-1:0], prev_val[2*RW-1 -: 2]};
      assign trial  = {prev_root, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {prev_root[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {prev_root[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= {prev_val[2*RW-3:0], 2'b00};
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

>>> sv/pqts_div.sv
// pqts_div: pipelined restoring divider, one quotient bit per register stage.
// Starts from a partial remainder below the divisor; standalone, no package dependency.
module pqts_div #(
   parameter int DW = 32,
   parameter int QW = 30,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_low,
   input  logic [DW-1:0] in_dvs,
   input  logic [SW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [DW-1:0] dvs_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic          vld_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW-1:0] prev_rem;
      logic [QW-1:0] prev_low;
      logic [DW-1:0] prev_dvs;
      logic [QW-1:0] prev_quo;
      logic [SW-1:0] prev_side;
      logic          prev_vld;
      logic [DW:0]   trial;
      logic [DW:0]   dvs_ext;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_rem  = in_rem;
         assign prev_low  = in_low;
         assign prev_dvs  = in_dvs;
         assign prev_quo  = '0;
         assign prev_side = in_side;
         assign prev_vld  = in_vld;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_low  = low_ff[k-1];
         assign prev_dvs  = dvs_ff[k-1];
         assign prev_quo  = quo_ff[k-1];
         assign prev_side = side_ff[k-1];
         assign prev_vld  = vld_ff[k-1];
      end

      assign trial   = {prev_rem, prev_low[QW-1]};
      assign dvs_ext = {1'b0, prev_dvs};
      assign diff    = trial - dvs_ext;

      always_comb begin
         if (trial >= dvs_ext) begin
            rem_in = diff[DW-1:0];
            quo_in = {prev_quo[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {prev_quo[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= {prev_low[QW-2:0], 1'b0};
            dvs_ff[k]  <= prev_dvs;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quo  = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

>>> sv/pqts_unit.sv
// pqts_unit: projects one corner onto the unit sphere (block scale, length, divide).
// Depends on pqts_pkg, pqts_isqrt and pqts_div.
module pqts_unit
   import pqts_pkg::*;
#(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic signed [CW-1:0] in_x,
   input  logic signed [CW-1:0] in_y,
   input  logic signed [CW-1:0] in_z,
   output logic                 out_vld,
   output uvec_type             out_u
);

   localparam int PW    = $clog2(CW);
   localparam int EXT_W = CW + MAG_W - 1;

   logic [CW-1:0]       raw [3];
   logic [2:0]          neg1_in;
   logic [CW-1:0]       mag1_in [3];
   logic [2:0]          neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [CW-1:0]       mag1_ff [3];
   logic [CW-1:0]       mag2_ff [3];
   logic [CW-1:0]       mag3_ff [3];
   logic [CW-1:0]       m2_in, m2_ff;
   logic [PW-1:0]       p3_in, p3_ff;
   logic                zero3_ff, zero4_ff, zero5_ff, zero6_ff;
   logic [EXT_W-1:0]    ext4 [3];
   logic [MAG_W-1:0]    scaled4_ff [3];
   logic [MAG_W-1:0]    scaled5_ff [3];
   logic [MAG_W-1:0]    scaled6_ff [3];
   logic [2*MAG_W-1:0]  sq5_ff [3];
   logic [SUMSQ_W-1:0]  sum6_ff;
   logic                vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff, vld7_ff;
   corner_side_type     side6, side_n;
   logic                n_vld;
   logic [NORM_W-1:0]   n_root;
   logic [2:0]          q_vld;
   logic [QUO_W-1:0]    q_quo [3];
   lane_side_type       q_side [3];
   logic signed [UNIT_W-1:0] u7_in [3];
   uvec_type            u7_ff;

   assign raw[0] = in_x;
   assign raw[1] = in_y;
   assign raw[2] = in_z;

   // sign and magnitude; the most negative code maps to 2^(CW-1)
   for (genvar k = 0; k < 3; k++) begin : g_abs
      assign neg1_in[k] = raw[k][CW-1];
      assign mag1_in[k] = neg1_in[k] ? (~raw[k] + CW'(1)) : raw[k];
   end

   always_comb begin
      m2_in = mag1_ff[0];
      if (mag1_ff[1] > m2_in) begin
         m2_in = mag1_ff[1];
      end
      if (mag1_ff[2] > m2_in) begin
         m2_in = mag1_ff[2];
      end
   end

   always_comb begin
      p3_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (m2_ff[i]) begin
            p3_in = PW'(i);
         end
      end
   end

   // common shift puts the largest MSB at bit MAG_W-1; right shifts truncate
   for (genvar k = 0; k < 3; k++) begin : g_shift
      assign ext4[k] = {mag3_ff[k], (MAG_W - 1)'(0)} >> p3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= q_vld[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= neg1_in;
         neg2_ff  <= neg1_ff;
         neg3_ff  <= neg2_ff;
         neg4_ff  <= neg3_ff;
         neg5_ff  <= neg4_ff;
         neg6_ff  <= neg5_ff;
         m2_ff    <= m2_in;
         p3_ff    <= p3_in;
         zero3_ff <= (m2_ff == '0);
         zero4_ff <= zero3_ff;
         zero5_ff <= zero4_ff;
         zero6_ff <= zero5_ff;
         sum6_ff  <= SUMSQ_W'(sq5_ff[0]) + SUMSQ_W'(sq5_ff[1]) + SUMSQ_W'(sq5_ff[2]);
         for (int k = 0; k < 3; k++) begin
            mag1_ff[k]    <= mag1_in[k];
            mag2_ff[k]    <= mag1_ff[k];
            mag3_ff[k]    <= mag2_ff[k];
            scaled4_ff[k] <= ext4[k][MAG_W-1:0];
            scaled5_ff[k] <= scaled4_ff[k];
            scaled6_ff[k] <= scaled5_ff[k];
            sq5_ff[k]     <= scaled4_ff[k] * scaled4_ff[k];
         end
      end
   end

   always_comb begin
      side6.zero = zero6_ff;
      side6.neg  = neg6_ff;
      for (int k = 0; k < 3; k++) begin
         side6.mag[k] = scaled6_ff[k];
      end
   end

   pqts_isqrt #(
      .RW (NORM_W),
      .SW ($bits(corner_side_type))
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld6_ff),
      .in_val   (sum6_ff),
      .in_side  (side6),
      .out_vld  (n_vld),
      .out_root (n_root),
      .out_side (side_n)
   );

   // numerator is mag << 29: top bits seed the remainder, mag[0] is the next bit
   for (genvar k = 0; k < 3; k++) begin : g_lane
      lane_side_type lane_in;
      assign lane_in.zero = side_n.zero;
      assign lane_in.neg  = side_n.neg[k];

      pqts_div #(
         .DW (NORM_W),
         .QW (QUO_W),
         .SW ($bits(lane_side_type))
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (n_vld),
         .in_rem   (NORM_W'(side_n.mag[k][MAG_W-1:1])),
         .in_low   ({side_n.mag[k][0], (QUO_W - 1)'(0)}),
         .in_dvs   (n_root),
         .in_side  (lane_in),
         .out_vld  (q_vld[k]),
         .out_quo  (q_quo[k]),
         .out_side (q_side[k])
      );

      always_comb begin
         if (q_side[k].zero) begin
            u7_in[k] = '0;
         end else if (q_side[k].neg) begin
            u7_in[k] = -$signed({1'b0, q_quo[k]});
         end else begin
            u7_in[k] = $signed({1'b0, q_quo[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u7_ff.x <= u7_in[0];
         u7_ff.y <= u7_in[1];
         u7_ff.z <= u7_in[2];
      end
   end

   assign out_vld = vld7_ff;
   assign out_u   = u7_ff;

endmodule

>>> sv/pqts_tail.sv
// pqts_tail: diagonal cross product, its length, the half-area root and final scaling.
// Depends on pqts_pkg and pqts_isqrt.
module pqts_tail
   import pqts_pkg::*;
#(
   parameter int SIDE_W = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  uvec_type            in_u0,
   input  uvec_type            in_u1,
   input  uvec_type            in_u2,
   input  uvec_type            in_u3,
   input  logic [RADIUS_W-1:0] radius,
   output logic                out_vld,
   output logic [SIDE_W-1:0]   out_side
);

   localparam logic [31:0] SIDE_MAX = 32'((64'(1) << SIDE_W) - 64'(1));

   logic signed [UNIT_W-1:0] c0 [3];
   logic signed [UNIT_W-1:0] c1 [3];
   logic signed [UNIT_W-1:0] c2 [3];
   logic signed [UNIT_W-1:0] c3 [3];
   logic signed [DIFF_W-1:0] a_ff [3];
   logic signed [DIFF_W-1:0] b_ff [3];
   logic signed [PROD_W-1:0] pr_ff [6];
   logic signed [PROD_W-1:0] cr_ff [3];
   logic        [PROD_W-1:0] cabs [3];
   logic [CMAG_W-1:0]        cm_ff [3];
   logic [2*CMAG_W-1:0]      csq_ff [3];
   logic [SUMSQ_W-1:0]       s_ff;
   logic                     vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff, vld6_ff;
   logic                     vld7_ff, vld8_ff;
   logic                     len_vld, q_vld;
   logic [LEN_W-1:0]         len;
   logic [ROOT_W-1:0]        q_root;
   logic [RQ_W-1:0]          rq_ff;
   logic [RQ_W:0]            rounded;
   logic [RAW_W-1:0]         raw_side;
   logic [SIDE_W-1:0]        side8_in, side8_ff;

   assign c0[0] = in_u0.x;  assign c0[1] = in_u0.y;  assign c0[2] = in_u0.z;
   assign c1[0] = in_u1.x;  assign c1[1] = in_u1.y;  assign c1[2] = in_u1.z;
   assign c2[0] = in_u2.x;  assign c2[1] = in_u2.y;  assign c2[2] = in_u2.z;
   assign c3[0] = in_u3.x;  assign c3[1] = in_u3.y;  assign c3[2] = in_u3.z;

   for (genvar k = 0; k < 3; k++) begin : g_abs
      assign cabs[k] = cr_ff[k][PROD_W-1] ? PROD_W'(-cr_ff[k]) : PROD_W'(cr_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= q_vld;
         vld8_ff <= vld7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k]   <= DIFF_W'(c2[k]) - DIFF_W'(c0[k]);
            b_ff[k]   <= DIFF_W'(c3[k]) - DIFF_W'(c1[k]);
            cr_ff[k]  <= pr_ff[2*k] - pr_ff[2*k+1];
            cm_ff[k]  <= cabs[k][CROSS_SHIFT+CMAG_W-1:CROSS_SHIFT];
            csq_ff[k] <= cm_ff[k] * cm_ff[k];
         end
         pr_ff[0] <= a_ff[1] * b_ff[2];
         pr_ff[1] <= a_ff[2] * b_ff[1];
         pr_ff[2] <= a_ff[2] * b_ff[0];
         pr_ff[3] <= a_ff[0] * b_ff[2];
         pr_ff[4] <= a_ff[0] * b_ff[1];
         pr_ff[5] <= a_ff[1] * b_ff[0];
         s_ff     <= SUMSQ_W'(csq_ff[0]) + SUMSQ_W'(csq_ff[1]) + SUMSQ_W'(csq_ff[2]);
         rq_ff    <= RQ_W'(radius) * RQ_W'(q_root);
         side8_ff <= side8_in;
      end
   end

   pqts_isqrt #(
      .RW (LEN_W),
      .SW (1)
   ) u_len (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld6_ff),
      .in_val   (s_ff),
      .in_side  (1'b0),
      .out_vld  (len_vld),
      .out_root (len),
      .out_side ()
   );

   pqts_isqrt #(
      .RW (ROOT_W),
      .SW (1)
   ) u_half (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (len_vld),
      .in_val   ((2*ROOT_W)'({len, LEN_SHIFT'(0)})),
      .in_side  (1'b0),
      .out_vld  (q_vld),
      .out_root (q_root),
      .out_side ()
   );

   // round half up, then clamp to the side range
   assign rounded  = {1'b0, rq_ff} + ((RQ_W + 1)'(1) << (ROUND_SHIFT - 1));
   assign raw_side = rounded[RQ_W:ROUND_SHIFT];

   always_comb begin
      if (32'(raw_side) > SIDE_MAX) begin
         side8_in = SIDE_W'(SIDE_MAX);
      end else begin
         side8_in = SIDE_W'(raw_side);
      end
   end

   assign out_vld  = vld8_ff;
   assign out_side = side8_ff;

endmodule

>>> sv/projected_quad_texture_size.sv
// projected_quad_texture_size: texture side length of a quad as seen from the origin.
// Throughput one transaction per cycle while the skid stage is empty.
// Depth is set by the bit-per-stage square roots (32 + 32 + 31) and dividers (30 stages).
// Reset (synchronous, active high) empties the pipeline and loads pixels_per_degree = 10.0.
// Depends on pqts_pkg, pqts_unit, pqts_tail, pqts_isqrt and pqts_div.
module projected_quad_texture_size
   import pqts_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int SIDE_WIDTH  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [COORD_WIDTH-1:0] req_p0_z,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_z,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_z,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SIDE_WIDTH-1:0]         rsp_side_length,
   input  logic                          csr_wr_en,
   input  logic [PPD_W-1:0]              csr_wr_data
);

   logic [PPD_W-1:0]          ppd_ff;
   logic [PPD_W+RADIUS_W-1:0] radius_prod;
   logic [RADIUS_W-1:0]       radius_ff;
   logic                      en;
   logic [3:0]                u_vld;
   uvec_type                  u_vec [4];
   logic                      tail_vld;
   logic [SIDE_WIDTH-1:0]     tail_side;
   logic                      rsp_valid_ff;
   logic [SIDE_WIDTH-1:0]     rsp_side_ff;
   logic                      skid_vld_ff;
   logic [SIDE_WIDTH-1:0]     skid_side_ff;
   logic                      rsp_take;

   // Pixels-per-degree register; write only while the block is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         ppd_ff <= PPD_RESET;
      end else if (csr_wr_en) begin
         ppd_ff <= csr_wr_data;
      end
   end

   // Radius r = ppd * 180/pi in Q.16, rounded and registered from the ppd register.
   assign radius_prod = ppd_ff * RAD_TO_DEG_Q24
                      + ((PPD_W + RADIUS_W)'(1) << (RADIUS_SHIFT - 1));

   always_ff @(posedge clock) begin
      radius_ff <= radius_prod[RADIUS_SHIFT+RADIUS_W-1:RADIUS_SHIFT];
   end

   // The whole pipeline advances together; only a full skid stage holds it.
   assign en        = !skid_vld_ff;
   assign req_ready = en;

   pqts_unit #(.CW(COORD_WIDTH)) u_corner0 (
      .clock (clock), .reset (reset), .en (en), .in_vld (req_valid),
      .in_x (req_p0_x), .in_y (req_p0_y), .in_z (req_p0_z),
      .out_vld (u_vld[0]), .out_u (u_vec[0])
   );

   pqts_unit #(.CW(COORD_WIDTH)) u_corner1 (
      .clock (clock), .reset (reset), .en (en), .in_vld (req_valid),
      .in_x (req_p1_x), .in_y (req_p1_y), .in_z (req_p1_z),
      .out_vld (u_vld[1]), .out_u (u_vec[1])
   );

   pqts_unit #(.CW(COORD_WIDTH)) u_corner2 (
      .clock (clock), .reset (reset), .en (en), .in_vld (req_valid),
      .in_x (req_p2_x), .in_y (req_p2_y), .in_z (req_p2_z),
      .out_vld (u_vld[2]), .out_u (u_vec[2])
   );

   pqts_unit #(.CW(COORD_WIDTH)) u_corner3 (
      .clock (clock), .reset (reset), .en (en), .in_vld (req_valid),
      .in_x (req_p3_x), .in_y (req_p3_y), .in_z (req_p3_z),
      .out_vld (u_vld[3]), .out_u (u_vec[3])
   );

   pqts_tail #(.SIDE_W(SIDE_WIDTH)) u_tail (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (u_vld[0]),
      .in_u0    (u_vec[0]),
      .in_u1    (u_vec[1]),
      .in_u2    (u_vec[2]),
      .in_u3    (u_vec[3]),
      .radius   (radius_ff),
      .out_vld  (tail_vld),
      .out_side (tail_side)
   );

   // Output register plus one skid entry: a finished transaction drops into
   // the skid when the output is held, so the input side keeps flowing.
   assign rsp_take = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (tail_vld) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_take) begin
            rsp_side_ff <= skid_side_ff;
         end
      end else if (tail_vld) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_side_ff <= tail_side;
         end else begin
            skid_side_ff <= tail_side;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_side_length = rsp_side_ff;

`ifndef ASSERT_OFF
   a_skid_needs_output : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid holds a transaction while the output register is empty");

   a_stalled_result_parks : assert property (@(posedge clock) disable iff (reset)
      (tail_vld && !skid_vld_ff && rsp_valid_ff && !rsp_ready) |=> skid_vld_ff)
      else $error("finished transaction not parked in the skid stage");

   a_reset_empties : assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !skid_vld_ff))
      else $error("output stages not empty after reset");
`endif

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for projected_quad_texture_size (quad to texture side).
// Depends on pqts_pkg for PPD_W and PPD_RESET and on the block itself; a local predictor computes sides.
module testbench;
   import pqts_pkg::*;

   localparam int CW       = 32;
   localparam int SW       = 15;
   localparam int LATENCY  = 140;
   localparam int WATCHDOG = 20000;
   localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

   typedef struct packed {
      logic [3:0][2:0][CW-1:0] corner;  // corner[i][axis]
   } quad_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [CW-1:0] req_c [4][3];
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [SW-1:0] rsp_side_length;
   logic          csr_wr_en = 1'b0;
   logic [PPD_W-1:0] csr_wr_data = '0;

   // pending quads for the driver, expected sides for the monitor
   quad_type      quad_queue[$];
   logic [SW-1:0] side_queue[$];
   logic [15:0]   ppd_model;

   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;     // cycles left in a forced receiver stall
   int quiet_cycles = 0;
   bit timed_out = 1'b0;
   int zero_sides = 0;
   int sat_sides = 0;

   projected_quad_texture_size i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_p0_x        (req_c[0][0]),
      .req_p0_y        (req_c[0][1]),
      .req_p0_z        (req_c[0][2]),
      .req_p1_x        (req_c[1][0]),
      .req_p1_y        (req_c[1][1]),
      .req_p1_z        (req_c[1][2]),
      .req_p2_x        (req_c[2][0]),
      .req_p2_y        (req_c[2][1]),
      .req_p2_z        (req_c[2][2]),
      .req_p3_x        (req_c[3][0]),
      .req_p3_y        (req_c[3][1]),
      .req_p3_z        (req_c[3][2]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_side_length (rsp_side_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // bitwise integer square root, floor
   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // project one corner onto the unit sphere, signed Q1.29
   function automatic void project_corner(input logic [2:0][CW-1:0] raw,
                                          output longint unit [3]);
      logic [63:0] mag [3];
      bit          neg [3];
      logic [63:0] peak;
      logic [63:0] sum;
      logic [63:0] norm;
      logic [63:0] quo;
      int          msb;
      peak = 0;
      for (int k = 0; k < 3; k++) begin
         neg[k] = raw[k][CW-1];
         mag[k] = neg[k] ? {32'd0, -raw[k]} : {32'd0, raw[k]};
         if (mag[k] > peak) peak = mag[k];
      end
      if (peak == 0) begin
         for (int k = 0; k < 3; k++) unit[k] = 0;
         return;
      end
      msb = 63;
      while (!peak[msb]) msb--;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         if (msb > 30) mag[k] = mag[k] >> (msb - 30);
         else if (msb < 30) mag[k] = mag[k] << (30 - msb);
         sum += mag[k] * mag[k];
      end
      norm = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
         quo = (mag[k] << 29) / norm;
         unit[k] = neg[k] ? -longint'(quo) : longint'(quo);
      end
   endfunction

   function automatic logic [SW-1:0] predict_side(input quad_type q);
      longint      u [4][3];
      longint      da [3];
      longint      db [3];
      longint      cr [3];
      logic [63:0] sum;
      logic [63:0] cm;
      logic [63:0] len;
      logic [63:0] root;
      logic [63:0] radius;
      logic [63:0] side;
      for (int i = 0; i < 4; i++) project_corner(q.corner[i], u[i]);
      for (int k = 0; k < 3; k++) begin
         da[k] = u[2][k] - u[0][k];
         db[k] = u[3][k] - u[1][k];
      end
      cr[0] = da[1] * db[2] - da[2] * db[1];
      cr[1] = da[2] * db[0] - da[0] * db[2];
      cr[2] = da[0] * db[1] - da[1] * db[0];
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         cm = (cr[k] < 0 ? -cr[k] : cr[k]);
         cm = cm >> 30;
         sum += cm * cm;
      end
      len = int_sqrt(sum);
      root = int_sqrt(len << 29);
      radius = ({48'd0, ppd_model} * DEG_PER_RAD_Q24 + (64'd1 << 15)) >> 16;
      side = (radius * root + (64'd1 << 44)) >> 45;
      if (side > (64'd1 << SW) - 1) side = (64'd1 << SW) - 1;
      return side[SW-1:0];
   endfunction

   // random coordinate: mix of full range, small values and edge values
   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3, 4: return $urandom_range(0, 4095) - 2048;
         5, 6: return ($urandom_range(0, 20) - 10) << 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic quad_type rand_quad();
      quad_type q;
      logic [CW-1:0] cx;
      logic [CW-1:0] cy;
      logic [CW-1:0] half;
      int sel;
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
         foreach (q.corner[i, k]) q.corner[i][k] = rand_coord();
      end else begin
         // a plausible quad: square of random size at random distance, in front unless sel is 3
         cx = $urandom_range(0, 40) << 16;
         cy = $urandom_range(0, 40) << 16;
         half = $urandom_range(1, 1 << 20);
         for (int i = 0; i < 4; i++) begin
            q.corner[i][0] = cx + ((i == 1 || i == 2) ? half : -half);
            q.corner[i][1] = cy + ((i >= 2) ? half : -half);
            q.corner[i][2] = sel == 3 ? $urandom : -($urandom_range(1, 1 << 24));
         end
      end
      return q;
   endfunction

   task automatic push_quad(input quad_type q);
      quad_queue.push_back(q);
   endtask

   task automatic wait_drained();
      while (quad_queue.size() != 0 || req_valid || side_queue.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_ppd(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ppd_model = value;
   endtask

   // driver: present queued quads, hold each until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (req_valid) sent++;
            if (quad_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               quad_type q;
               q = quad_queue.pop_front();
               side_queue.push_back(predict_side(q));
               for (int i = 0; i < 4; i++)
                  for (int k = 0; k < 3; k++) req_c[i][k] <= q.corner[i][k];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stall on the result side, compare each side with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (side_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result side=%0d", rsp_side_length);
            end else begin
               logic [SW-1:0] want;
               want = side_queue.pop_front();
               checked++;
               if (want == 0) zero_sides++;
               if (&want) sat_sides++;
               if (rsp_side_length !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("side mismatch: expected %0d actual %0d", want, rsp_side_length);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: count cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      quad_type q;
      logic [15:0] ppd_set [4];
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 3; k++) req_c[i][k] = '0;
      ppd_model = PPD_RESET;
      ppd_set[0] = 16'hffff;
      ppd_set[1] = 16'd0;
      ppd_set[2] = 16'd1;
      ppd_set[3] = 16'd2560;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all corners at the origin, degenerate and extreme corners
      q = '0;
      push_quad(q);
      foreach (q.corner[i, k]) q.corner[i][k] = 32'h8000_0000;
      push_quad(q);
      foreach (q.corner[i, k]) q.corner[i][k] = 32'h7fff_ffff;
      push_quad(q);
      // front-facing square with corners at +-1 and z = -1, then the same with one corner at the origin
      for (int i = 0; i < 4; i++) begin
         q.corner[i][0] = (i == 1 || i == 2) ? 32'h0001_0000 : 32'hffff_0000;
         q.corner[i][1] = (i >= 2) ? 32'h0001_0000 : 32'hffff_0000;
         q.corner[i][2] = 32'hffff_0000;
      end
      push_quad(q);
      q.corner[0] = '0;
      push_quad(q);
      // wide quad close in: large side
      for (int i = 0; i < 4; i++) begin
         q.corner[i][0] = (i == 1 || i == 2) ? 32'h7fff_ffff : 32'h8000_0000;
         q.corner[i][1] = (i >= 2) ? 32'h7fff_ffff : 32'h8000_0000;
         q.corner[i][2] = 32'hffff_ffff;
      end
      push_quad(q);
      // tiny coordinates, single LSBs
      foreach (q.corner[i, k]) q.corner[i][k] = (i + k) % 3 == 0 ? 32'd1 : 32'hffff_ffff;
      push_quad(q);
      for (int n = 0; n < 8; n++) push_quad(rand_quad());
      wait_drained();
      write_ppd(16'hffff);
      for (int n = 0; n < 8; n++) push_quad(rand_quad());
      push_quad(q);
      wait_drained();

      // random phases with different idling patterns and resolutions;
      // the stalled phase sends more quads than the pipeline holds
      for (int ph = 0; ph < 4; ph++) begin
         write_ppd(ph == 3 ? 16'($urandom) : ppd_set[ph]);
         send_idle_pct = ph == 0 ? 6 : (ph == 1 ? 56 : 0);
         recv_idle_pct = ph == 0 ? 56 : (ph == 1 ? 6 : 0);
         if (ph == 2) hold_off = 400;  // long receiver stall fills the pipeline
         for (int n = 0; n < (ph == 2 ? 200 : 75); n++) push_quad(rand_quad());
         wait_drained();
      end

      $display("covered %0d quads over several resolutions, %0d zero and %0d saturated sides",
               checked, zero_sides, sat_sides);
      if (mismatches == 0 && side_queue.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> files.f
sv/pqts_pkg.sv
sv/pqts_isqrt.sv
sv/pqts_div.sv
sv/pqts_unit.sv
sv/pqts_tail.sv
sv/projected_quad_texture_size.sv
bench/testbench.sv
